[hdl/bqd_pkg.sv]
// ----------------------------------------------------------------------------
// bqd_pkg - biquad filter shared types and microcode
// Datapath widths, control word layout and the sequencer program.
// ----------------------------------------------------------------------------
package bqd_pkg;

  localparam int COEF_W    = 32;
  localparam int FEED_W    = 32;
  localparam int PROD_W    = COEF_W + FEED_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int DELAY_W   = 48;
  localparam int NUM_COEFS = 5;
  localparam int IDX_W     = 3;
  localparam int STEP_W    = 3;

  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [FEED_W-1:0]  feed_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [DELAY_W-1:0] delay_t;

  typedef enum logic [IDX_W-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } reg_idx_e;

  typedef enum logic {
    MUL_X,
    MUL_YF
  } mul_b_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_PROD_D1,
    ACC_PROD_D2,
    ACC_PROD
  } acc_op_e;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_WAIT_OUT,
    JMP_START
  } jmp_e;

  typedef struct packed {
    jmp_e     jmp;
    logic     mul_en;
    reg_idx_e mul_a;
    mul_b_e   mul_b;
    acc_op_e  acc_op;
    logic     y_load;
    logic     d1_load;
    logic     d2_load;
  } ucw_t;

  typedef struct packed {
    logic     x_load;
    logic     mul_en;
    reg_idx_e mul_a;
    mul_b_e   mul_b;
    acc_op_e  acc_op;
    logic     y_load;
    logic     d1_load;
    logic     d2_load;
  } ctl_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
  } stat_t;

  // one sample: y = b0*x + d1; d1' = b1*x + d2 - a1*y; d2' = b2*x - a2*y
  function automatic ucw_t ucode(logic [STEP_W-1:0] step);
    ucw_t w;
    w = '0;
    w.jmp   = JMP_NEXT;
    w.mul_a = REG_B0;
    w.mul_b = MUL_X;
    w.acc_op = ACC_HOLD;
    case (step)
      3'd0: begin
        w.jmp = JMP_WAIT_IN;
      end
      3'd1: begin
        w.mul_en = 1'b1;
        w.mul_a  = REG_B0;
      end
      3'd2: begin
        w.acc_op = ACC_PROD_D1;
        w.mul_en = 1'b1;
        w.mul_a  = REG_B1;
      end
      3'd3: begin
        w.jmp    = JMP_WAIT_OUT;
        w.y_load = 1'b1;
        w.acc_op = ACC_PROD_D2;
      end
      3'd4: begin
        w.mul_en = 1'b1;
        w.mul_a  = REG_A1;
        w.mul_b  = MUL_YF;
      end
      3'd5: begin
        w.d1_load = 1'b1;
        w.mul_en  = 1'b1;
        w.mul_a   = REG_B2;
      end
      3'd6: begin
        w.acc_op = ACC_PROD;
        w.mul_en = 1'b1;
        w.mul_a  = REG_A2;
        w.mul_b  = MUL_YF;
      end
      3'd7: begin
        w.d2_load = 1'b1;
        w.jmp     = JMP_START;
      end
      default: begin
        w.jmp = JMP_START;
      end
    endcase
    return w;
  endfunction

endpackage

[hdl/bqd_if.sv]
// ----------------------------------------------------------------------------
// bqd_if - biquad filter stream channels
// Sample input channel and filtered result channel, valid/ready.
// ----------------------------------------------------------------------------
interface bqd_in_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface bqd_out_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_out;
  logic                clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

[hdl/bqd_seq.sv]
// ----------------------------------------------------------------------------
// bqd_seq - biquad microcode sequencer
// Step counter over the control ROM with wait-for-input and wait-for-output.
// ----------------------------------------------------------------------------
module bqd_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bqd_pkg::stat_t stat_i,
  output bqd_pkg::ctl_t  ctl_o,
  output logic           in_ready_o
);

  logic [bqd_pkg::STEP_W-1:0] step_q, step_d;
  bqd_pkg::ucw_t              cw;
  logic                       hold;

  assign cw = bqd_pkg::ucode(step_q);

  assign hold = ((cw.jmp == bqd_pkg::JMP_WAIT_IN) && !stat_i.in_valid) ||
                ((cw.jmp == bqd_pkg::JMP_WAIT_OUT) && stat_i.out_busy);

  always_comb begin
    if (hold) begin
      step_d = step_q;
    end else if (cw.jmp == bqd_pkg::JMP_START) begin
      step_d = '0;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  always_comb begin
    in_ready_o    = (cw.jmp == bqd_pkg::JMP_WAIT_IN);
    ctl_o.x_load  = (cw.jmp == bqd_pkg::JMP_WAIT_IN) && stat_i.in_valid;
    ctl_o.mul_en  = cw.mul_en && !hold;
    ctl_o.mul_a   = cw.mul_a;
    ctl_o.mul_b   = cw.mul_b;
    ctl_o.acc_op  = hold ? bqd_pkg::ACC_HOLD : cw.acc_op;
    ctl_o.y_load  = cw.y_load && !hold;
    ctl_o.d1_load = cw.d1_load && !hold;
    ctl_o.d2_load = cw.d2_load && !hold;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

[hdl/bqd_dp.sv]
// ----------------------------------------------------------------------------
// bqd_dp - biquad datapath
// Coefficients, shared multiplier, accumulator, delays and result register.
// ----------------------------------------------------------------------------
module bqd_dp #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bqd_pkg::IDX_W-1:0]     cfg_idx_i,
  input  logic [bqd_pkg::COEF_W-1:0]    cfg_data_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in_i,
  input  bqd_pkg::ctl_t                 ctl_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out_o,
  output logic                          clipped_o,
  output logic                          out_busy_o
);

  localparam bqd_pkg::coef_t B0_ONE =
    bqd_pkg::coef_t'({{(bqd_pkg::COEF_W-1){1'b0}}, 1'b1} << COEF_FRAC_BITS);
  localparam bqd_pkg::acc_t HALF  = bqd_pkg::acc_t'(1) <<< (COEF_FRAC_BITS - 1);
  localparam bqd_pkg::acc_t D_MAX =
    bqd_pkg::acc_t'({1'b0, {(bqd_pkg::DELAY_W-1){1'b1}}});
  localparam bqd_pkg::acc_t D_MIN = ~D_MAX;
  localparam bqd_pkg::acc_t F_MAX =
    bqd_pkg::acc_t'({1'b0, {(bqd_pkg::FEED_W-1){1'b1}}});
  localparam bqd_pkg::acc_t F_MIN = ~F_MAX;
  localparam bqd_pkg::acc_t S_MAX =
    bqd_pkg::acc_t'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
  localparam bqd_pkg::acc_t S_MIN = ~S_MAX;

  typedef logic [bqd_pkg::IDX_W-1:0] cfg_idx_t;

  bqd_pkg::coef_t                coef_q [bqd_pkg::NUM_COEFS];
  logic signed [SAMPLE_WIDTH-1:0] x_q;
  bqd_pkg::prod_t                prod_q;
  bqd_pkg::acc_t                 acc_q, acc_d;
  bqd_pkg::feed_t                yf_q;
  bqd_pkg::delay_t               d1_q, d2_q;
  logic                          out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] sample_out_q;
  logic                          clipped_q;

  logic                          cfg_hit;
  bqd_pkg::coef_t                mul_a;
  bqd_pkg::feed_t                mul_b;
  bqd_pkg::acc_t                 diff;
  bqd_pkg::delay_t               diff_sat;
  bqd_pkg::acc_t                 y_full;
  bqd_pkg::feed_t                yf;
  logic signed [SAMPLE_WIDTH-1:0] ys;
  logic                          clip;

  assign cfg_hit = cfg_we_i && (cfg_idx_i < bqd_pkg::IDX_W'(bqd_pkg::NUM_COEFS));

  assign mul_a = coef_q[cfg_idx_t'(ctl_i.mul_a)];
  assign mul_b = (ctl_i.mul_b == bqd_pkg::MUL_X) ? bqd_pkg::feed_t'(x_q) : yf_q;

  always_comb begin
    case (ctl_i.acc_op)
      bqd_pkg::ACC_PROD_D1: acc_d = bqd_pkg::acc_t'(prod_q) + bqd_pkg::acc_t'(d1_q);
      bqd_pkg::ACC_PROD_D2: acc_d = bqd_pkg::acc_t'(prod_q) + bqd_pkg::acc_t'(d2_q);
      bqd_pkg::ACC_PROD:    acc_d = bqd_pkg::acc_t'(prod_q);
      default:              acc_d = acc_q;
    endcase
  end

  // delay update: accumulator less the feedback product, clamped to 48 bits
  always_comb begin
    diff = acc_q - bqd_pkg::acc_t'(prod_q);
    if (diff > D_MAX) begin
      diff_sat = D_MAX[bqd_pkg::DELAY_W-1:0];
    end else if (diff < D_MIN) begin
      diff_sat = D_MIN[bqd_pkg::DELAY_W-1:0];
    end else begin
      diff_sat = diff[bqd_pkg::DELAY_W-1:0];
    end
  end

  // round half up, then clamp for feedback and for the output
  always_comb begin
    y_full = (acc_q + HALF) >>> COEF_FRAC_BITS;
    if (y_full > F_MAX) begin
      yf = F_MAX[bqd_pkg::FEED_W-1:0];
    end else if (y_full < F_MIN) begin
      yf = F_MIN[bqd_pkg::FEED_W-1:0];
    end else begin
      yf = y_full[bqd_pkg::FEED_W-1:0];
    end
    clip = 1'b0;
    if (y_full > S_MAX) begin
      ys   = S_MAX[SAMPLE_WIDTH-1:0];
      clip = 1'b1;
    end else if (y_full < S_MIN) begin
      ys   = S_MIN[SAMPLE_WIDTH-1:0];
      clip = 1'b1;
    end else begin
      ys = y_full[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0] <= B0_ONE;
      for (int i = 1; i < bqd_pkg::NUM_COEFS; i++) begin
        coef_q[i] <= '0;
      end
    end else if (cfg_hit) begin
      coef_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_q <= '0;
      d2_q <= '0;
    end else if (cfg_hit) begin
      d1_q <= '0;
      d2_q <= '0;
    end else begin
      if (ctl_i.d1_load) begin
        d1_q <= diff_sat;
      end
      if (ctl_i.d2_load) begin
        d2_q <= diff_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.x_load) begin
      x_q <= sample_in_i;
    end
    if (ctl_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    acc_q <= acc_d;
    if (ctl_i.y_load) begin
      yf_q         <= yf;
      sample_out_q <= ys;
      clipped_q    <= clip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.y_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;
  assign clipped_o    = clipped_q;
  assign out_busy_o   = out_valid_q && !out_ready_i;

`ifndef SYNTH
  a_cfg_clears_delays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> (d1_q == '0) && (d2_q == '0))
    else $error("delays not cleared after coefficient write");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.y_load |-> !out_busy_o)
    else $error("pending result overwritten");

  a_result_presented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.y_load |=> out_valid_q)
    else $error("result not presented after load");

  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_i.d1_load && ctl_i.d2_load) && !(ctl_i.y_load && ctl_i.x_load))
    else $error("conflicting microcode steps");
`endif

endmodule

[hdl/biquad_iir_filter_unit.sv]
// ----------------------------------------------------------------------------
// biquad_iir_filter_unit - second-order IIR filter, transposed direct form II
// Microcoded datapath with one shared 32x32 multiplier.
//
//   channel   dir  payload                      transfer when
//   in_ch     in   sample_in                    valid & ready
//   out_ch    out  sample_out, clipped          valid & ready
//   cfg       in   cfg_idx_i, cfg_data_i        cfg_we_i
//
// Per sample: a wait step plus seven microcode steps, set by
// the five products through the single multiplier.
// A held result stalls the sequencer at the output step only; the next
// sample is taken while a result waits.
// Reset clears the delays and loads unity gain (b0 = 1.0, others 0).
// Any valid coefficient write clears both delays.
// ----------------------------------------------------------------------------
module biquad_iir_filter_unit #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  bqd_in_if.sink                     in_ch,
  bqd_out_if.source                  out_ch,
  input  logic                       cfg_we_i,
  input  logic [bqd_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [bqd_pkg::COEF_W-1:0] cfg_data_i
);

  bqd_pkg::stat_t stat;
  bqd_pkg::ctl_t  ctl;
  logic           in_ready;
  logic           out_busy;

  assign stat.in_valid = in_ch.valid;
  assign stat.out_busy = out_busy;
  assign in_ch.ready   = in_ready;

  bqd_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (stat),
    .ctl_o      (ctl),
    .in_ready_o (in_ready)
  );

  bqd_dp #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .sample_in_i  (in_ch.sample_in),
    .ctl_i        (ctl),
    .out_ready_i  (out_ch.ready),
    .out_valid_o  (out_ch.valid),
    .sample_out_o (out_ch.sample_out),
    .clipped_o    (out_ch.clipped),
    .out_busy_o   (out_busy)
  );

endmodule
